// File: rtl/mma_pkg.sv
package mma_pkg;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_LAST = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  localparam logic [3:0] CLS_PROGRAM = 4'hC;
  localparam logic [3:0] CLS_CPRESS  = 4'hD;
  localparam logic [3:0] CLS_BEND    = 4'hE;

  localparam logic [2:0] KIND_BEND = 3'd6;

  localparam logic [15:0] ERR_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  held_status;
    logic [6:0]  held_first_data;
    logic [15:0] framing_errors;
  } parse_state_t;

  typedef struct packed {
    logic        msg_ready;
    logic [2:0]  msg_kind;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [13:0] bend_amount;
    logic [15:0] error_total;
  } msg_t;

endpackage

// File: rtl/mma_rx_if.sv
interface mma_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/mma_msg_if.sv
interface mma_msg_if;
  logic        valid;
  logic        ready;
  logic        msg_ready;
  logic [2:0]  msg_kind;
  logic [6:0]  data_first;
  logic [6:0]  data_second;
  logic [13:0] bend_amount;
  logic [15:0] error_total;

  modport source (
    output valid, output msg_ready, output msg_kind, output data_first,
    output data_second, output bend_amount, output error_total, input ready
  );
  modport sink (
    input valid, input msg_ready, input msg_kind, input data_first,
    input data_second, input bend_amount, input error_total, output ready
  );
endinterface

// File: rtl/mma_decode.sv
module mma_decode (
  input  mma_pkg::parse_state_t cur,
  input  logic [7:0]            rx_byte,
  input  logic [3:0]            listen_channel,
  output mma_pkg::parse_state_t nxt,
  output mma_pkg::msg_t         res
);
  import mma_pkg::*;

  logic       is_status;
  logic       err;
  logic       one_data;
  logic       new_one_data;
  logic [6:0] d1;
  logic [6:0] d2;

  assign is_status    = rx_byte[7];
  assign one_data     = (cur.held_status[7:4] == CLS_PROGRAM) ||
                        (cur.held_status[7:4] == CLS_CPRESS);
  assign new_one_data = (rx_byte[7:4] == CLS_PROGRAM) || (rx_byte[7:4] == CLS_CPRESS);
  assign d1 = one_data ? rx_byte[6:0] : cur.held_first_data;
  assign d2 = one_data ? 7'd0 : rx_byte[6:0];

  always_comb begin
    nxt                = cur;
    res                = '0;
    err                = 1'b0;
    if (cur.phase == PHASE_TWO || cur.phase == PHASE_LAST) begin
      if (is_status) begin
        err       = 1'b1;
        nxt.phase = PHASE_IDLE;
      end else if (cur.phase == PHASE_TWO) begin
        nxt.held_first_data = rx_byte[6:0];
        nxt.phase           = PHASE_LAST;
      end else begin
        nxt.phase = PHASE_IDLE;
        if (cur.held_status[3:0] == listen_channel) begin
          res.msg_ready   = 1'b1;
          res.msg_kind    = cur.held_status[6:4];
          res.data_first  = d1;
          res.data_second = d2;
          if (cur.held_status[7:4] == CLS_BEND) begin
            res.bend_amount = {d2, d1};
          end
        end
      end
    end else begin
      if (!is_status) begin
        err       = 1'b1;
        nxt.phase = PHASE_IDLE;
      end else begin
        nxt.held_status = rx_byte;
        nxt.phase       = new_one_data ? PHASE_LAST : PHASE_TWO;
      end
    end
    if (err && cur.framing_errors != ERR_MAX) begin
      nxt.framing_errors = cur.framing_errors + 16'd1;
    end
    res.error_total = nxt.framing_errors;
  end

endmodule

// File: rtl/midi_message_assembler_core.sv
// Assembles MIDI channel messages from received bytes, one request per byte, and returns one
// result request for every byte taken. A byte is taken in every cycle while the result register
// is empty or being drained, so the sustained rate is one byte per cycle; the single result register
// shows each result in the cycle after its byte. A status byte opens a message (program change and
// channel pressure take one data byte, all other classes two, with no running status); the result
// flags msg_ready only when the message completes on the channel held in listen_channel, which the
// user must write through cfg_wr_en/cfg_wr_data only while the block is idle (unchecked). error_total
// counts data bytes seen while idle and status bytes that cut a message short, saturating at 65535.
module midi_message_assembler_core (
  input  logic       clk,
  input  logic       rst,
  mma_rx_if.sink     rx,
  mma_msg_if.source  msg,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  import mma_pkg::*;

  logic         rx_fire;
  logic [3:0]   listen_channel;
  parse_state_t st;
  parse_state_t st_next;
  msg_t         res_next;
  msg_t         res;
  logic         out_valid;

  assign rx.ready = !out_valid || msg.ready;
  assign rx_fire  = rx.valid && rx.ready;

  mma_decode u_decode (
    .cur            (st),
    .rx_byte        (rx.rx_byte),
    .listen_channel (listen_channel),
    .nxt            (st_next),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= 4'd0;
    end else if (cfg_wr_en) begin
      listen_channel <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rx_fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (msg.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire) begin
      res <= res_next;
    end
  end

  assign msg.valid       = out_valid;
  assign msg.msg_ready   = res.msg_ready;
  assign msg.msg_kind    = res.msg_kind;
  assign msg.data_first  = res.data_first;
  assign msg.data_second = res.data_second;
  assign msg.bend_amount = res.bend_amount;
  assign msg.error_total = res.error_total;

  a_err_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> st.framing_errors >= $past(st.framing_errors))
    else $error("error count decreased");

  a_err_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    !rx_fire |=> $stable(st.framing_errors))
    else $error("error count changed without a byte");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    rx_fire |=> out_valid)
    else $error("taken byte produced no result");

  a_bend_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.bend_amount != 14'd0 |-> res.msg_kind == KIND_BEND)
    else $error("bend value on a non-bend message");

endmodule
